// ===== hw/rtl/tlca_pkg.sv =====
// ----------------------------------------------------------------------------
// tlca_pkg
// Shared types and constants of the tree common-ancestor engine.
// ----------------------------------------------------------------------------
package tlca_pkg;

    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 10;
    localparam int STEPS_W = 10;
    localparam int ANS_W   = 11;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    typedef enum logic [1:0] {
        OP_ATTACH   = 2'd0,
        OP_ANCESTOR = 2'd1,
        OP_KTH      = 2'd2,
        OP_DISTANCE = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t             op;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [STEPS_W-1:0]  steps;
    } query_t;

endpackage

// ===== hw/rtl/tree_lca_binary_lifting_top.sv =====
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_top
// Rooted-tree engine: binary-lifting ancestor table plus depth table, with
// common-ancestor, k-th ancestor and distance queries.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) takes one item per transfer: attach a node under a
//   parent (parent 0 for the root), or a query. Parents must be attached
//   before their children. Node numbers above MAX_NODES count as node 0.
//   Master channel (m_*) returns one answer per query; attach gives none.
//   One item is worked on at a time; s_tready is high only when idle.
//   Each step of a walk is a dependent read of the ancestor RAM, whose read
//   data is registered, so the walk advances one table level per cycle.
//   The answer waits in an output register; a stalled receiver holds the
//   finished result, and the engine stalls in its last step until the slot
//   frees. Reset clears control only; table contents are undefined until
//   written, and no clearing pass runs.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_top
    import tlca_pkg::*;
#(
    parameter int unsigned MAX_NODES = 1023,
    parameter int          LEVELS    = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] opcode, [11:2] node_a, [21:12] node_b, [31:22] steps
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [10:0] answer, [15:11] zero
    output logic [15:0] m_tdata
);

    // Node rows actually stored: node numbers never exceed both MAX_NODES
    // and the 10-bit field.
    localparam int NODE_CNT  = (MAX_NODES > 1023) ? 1024 : int'(MAX_NODES) + 1;
    localparam int NODE_AW   = $clog2(NODE_CNT);
    localparam int ANC_DEPTH = LEVELS * (2 ** NODE_AW);
    localparam int ANC_AW    = $clog2(ANC_DEPTH);

    query_t             item;
    logic [NODE_W-1:0]  raw_a, raw_b;

    logic               res_valid, res_ready;
    logic [ANS_W-1:0]   res_answer;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [ANS_W-1:0]   m_data_reg;

    logic                anc_we;
    logic [ANC_AW-1:0]   anc_waddr, anc_raddr0, anc_raddr1;
    logic [NODE_W-1:0]   anc_wdata, anc_rdata0, anc_rdata1;
    logic                dep_we;
    logic [NODE_AW-1:0]  dep_waddr, dep_raddr0, dep_raddr1;
    logic [DEPTH_W-1:0]  dep_wdata, dep_rdata0, dep_rdata1;

    // Unpack the transfer; out-of-range node numbers map to node 0.
    assign raw_a = s_tdata[11:2];
    assign raw_b = s_tdata[21:12];

    always_comb begin
        item.op     = opcode_t'(s_tdata[1:0]);
        item.node_a = (32'(raw_a) <= MAX_NODES) ? raw_a : '0;
        item.node_b = (32'(raw_b) <= MAX_NODES) ? raw_b : '0;
        item.steps  = s_tdata[31:22];
    end

    tlca_ctrl #(
        .LEVELS  (LEVELS),
        .NODE_AW (NODE_AW),
        .ANC_AW  (ANC_AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_answer (res_answer),
        .anc_we     (anc_we),
        .anc_waddr  (anc_waddr),
        .anc_wdata  (anc_wdata),
        .anc_raddr0 (anc_raddr0),
        .anc_raddr1 (anc_raddr1),
        .anc_rdata0 (anc_rdata0),
        .anc_rdata1 (anc_rdata1),
        .dep_we     (dep_we),
        .dep_waddr  (dep_waddr),
        .dep_wdata  (dep_wdata),
        .dep_raddr0 (dep_raddr0),
        .dep_raddr1 (dep_raddr1),
        .dep_rdata0 (dep_rdata0),
        .dep_rdata1 (dep_rdata1)
    );

    // Ancestor table: entry {level, node} is the 2^level-th ancestor.
    tlca_ram #(
        .DEPTH  (ANC_DEPTH),
        .DATA_W (NODE_W)
    ) u_anc_ram (
        .aclk   (aclk),
        .we     (anc_we),
        .waddr  (anc_waddr),
        .wdata  (anc_wdata),
        .raddr0 (anc_raddr0),
        .raddr1 (anc_raddr1),
        .rdata0 (anc_rdata0),
        .rdata1 (anc_rdata1)
    );

    // Depth table: one entry per node.
    tlca_ram #(
        .DEPTH  (NODE_CNT),
        .DATA_W (DEPTH_W)
    ) u_dep_ram (
        .aclk   (aclk),
        .we     (dep_we),
        .waddr  (dep_waddr),
        .wdata  (dep_wdata),
        .raddr0 (dep_raddr0),
        .raddr1 (dep_raddr1),
        .rdata0 (dep_rdata0),
        .rdata1 (dep_rdata1)
    );

    // Output register: load when empty or being drained this cycle.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_answer;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, m_data_reg};

endmodule

// ===== hw/rtl/tlca_ram.sv =====
// ----------------------------------------------------------------------------
// tlca_ram
// Synchronous RAM, one write port and two read ports, registered read data.
// A read of the address written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module tlca_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 10
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [DATA_W-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr0,
    input  logic [$clog2(DEPTH)-1:0]   raddr1,
    output logic [DATA_W-1:0]          rdata0,
    output logic [DATA_W-1:0]          rdata1
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata0_reg;
    logic [DATA_W-1:0] rdata1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= (we && (waddr == raddr0)) ? wdata : mem[raddr0];
        rdata1_reg <= (we && (waddr == raddr1)) ? wdata : mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ===== hw/rtl/tlca_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlca_ctrl
// Sequencer for attach and query items: walks the ancestor table one level
// a cycle and keeps the running nodes, depths and the answer.
// ----------------------------------------------------------------------------
module tlca_ctrl
    import tlca_pkg::*;
#(
    parameter int LEVELS  = 10,
    parameter int NODE_AW = 10,
    parameter int ANC_AW  = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  query_t               in_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [ANS_W-1:0]     res_answer,
    output logic                 anc_we,
    output logic [ANC_AW-1:0]    anc_waddr,
    output logic [NODE_W-1:0]    anc_wdata,
    output logic [ANC_AW-1:0]    anc_raddr0,
    output logic [ANC_AW-1:0]    anc_raddr1,
    input  logic [NODE_W-1:0]    anc_rdata0,
    input  logic [NODE_W-1:0]    anc_rdata1,
    output logic                 dep_we,
    output logic [NODE_AW-1:0]   dep_waddr,
    output logic [DEPTH_W-1:0]   dep_wdata,
    output logic [NODE_AW-1:0]   dep_raddr0,
    output logic [NODE_AW-1:0]   dep_raddr1,
    input  logic [DEPTH_W-1:0]   dep_rdata0,
    input  logic [DEPTH_W-1:0]   dep_rdata1
);

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LVLC_W = $clog2(LEVELS + 1);

    localparam logic [LVLC_W-1:0] LVL_TOP  = LVLC_W'(LEVELS);
    localparam logic [LVLC_W-1:0] LVL_LAST = LVLC_W'(LEVELS - 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DEPTH = 9'b000000010,
        ST_ATT   = 9'b000000100,
        ST_SWAP  = 9'b000001000,
        ST_LIFT  = 9'b000010000,
        ST_JUMP  = 9'b000100000,
        ST_FINAL = 9'b001000000,
        ST_DIST  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic [STEPS_W-1:0]  bits_reg, bits_next;
    logic [LVLC_W-1:0]   lvl_reg, lvl_next;
    logic                pend_reg, pend_next;
    logic [DEPTH_W-1:0]  da_reg, da_next;
    logic [DEPTH_W-1:0]  db_reg, db_next;
    logic [ANS_W-1:0]    res_reg, res_next;
    logic                za0_reg, za1_reg, zd0_reg, zd1_reg;

    // Node numbers and level presented to the table read ports this cycle.
    logic [NODE_W-1:0]   anc_rnode0, anc_rnode1;
    logic [LVL_W-1:0]    anc_rlvl;
    logic [NODE_W-1:0]   dep_rnode0, dep_rnode1;
    logic [LVL_W-1:0]    anc_wlvl;

    // Read data, with node zero forced to depth 0 and all-zero ancestors.
    logic [NODE_W-1:0]   anc_q0, anc_q1;
    logic [DEPTH_W-1:0]  dep_q0, dep_q1;

    assign anc_q0 = za0_reg ? '0 : anc_rdata0;
    assign anc_q1 = za1_reg ? '0 : anc_rdata1;
    assign dep_q0 = zd0_reg ? '0 : dep_rdata0;
    assign dep_q1 = zd1_reg ? '0 : dep_rdata1;

    assign anc_raddr0 = ANC_AW'({anc_rlvl, anc_rnode0[NODE_AW-1:0]});
    assign anc_raddr1 = ANC_AW'({anc_rlvl, anc_rnode1[NODE_AW-1:0]});
    assign anc_waddr  = ANC_AW'({anc_wlvl, a_reg[NODE_AW-1:0]});
    assign dep_raddr0 = dep_rnode0[NODE_AW-1:0];
    assign dep_raddr1 = dep_rnode1[NODE_AW-1:0];
    assign dep_waddr  = a_reg[NODE_AW-1:0];

    assign in_ready   = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res_answer = res_reg;

    always_comb begin
        logic [NODE_W-1:0]  v;
        logic [NODE_W-1:0]  na;
        logic [NODE_W-1:0]  nb;
        logic               swap;
        logic [DEPTH_W+1:0] span;

        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        bits_next  = bits_reg;
        lvl_next   = lvl_reg;
        pend_next  = pend_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        res_next   = res_reg;

        anc_we     = 1'b0;
        anc_wlvl   = '0;
        anc_wdata  = b_reg;
        anc_rnode0 = '0;
        anc_rnode1 = '0;
        anc_rlvl   = '0;
        dep_we     = 1'b0;
        dep_wdata  = '0;
        dep_rnode0 = '0;
        dep_rnode1 = '0;

        v    = pend_reg ? anc_q0 : a_reg;
        na   = (anc_q0 != anc_q1) ? anc_q0 : a_reg;
        nb   = (anc_q0 != anc_q1) ? anc_q1 : b_reg;
        swap = (dep_q0 < dep_q1);
        span = {2'b00, da_reg} + {2'b00, db_reg} - {1'b0, dep_q0, 1'b0};

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next   = in_item.op;
                    a_next    = in_item.node_a;
                    b_next    = in_item.node_b;
                    bits_next = in_item.steps;
                    lvl_next  = '0;
                    pend_next = 1'b0;
                    priority if (in_item.op == OP_ATTACH) begin
                        // attaching node zero is dropped
                        state_next = (in_item.node_a == '0) ? ST_IDLE : ST_DEPTH;
                    end else if (in_item.op == OP_KTH) begin
                        if ((32'(in_item.steps) >> LEVELS) != 0) begin
                            res_next   = '0;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_LIFT;
                        end
                    end else begin
                        state_next = ST_DEPTH;
                    end
                end
            end
            ST_DEPTH: begin
                if (op_reg == OP_ATTACH) begin
                    // level 0 holds the parent; fetch the parent's depth
                    anc_we     = 1'b1;
                    anc_wlvl   = '0;
                    anc_wdata  = b_reg;
                    anc_rnode0 = b_reg;
                    dep_rnode0 = b_reg;
                    lvl_next   = LVLC_W'(1);
                    state_next = ST_ATT;
                end else begin
                    dep_rnode0 = a_reg;
                    dep_rnode1 = b_reg;
                    state_next = ST_SWAP;
                end
            end
            ST_ATT: begin
                if (lvl_reg == LVLC_W'(1)) begin
                    dep_we    = 1'b1;
                    dep_wdata = (b_reg == '0) ? '0 :
                                (dep_q0 == DEPTH_MAX) ? DEPTH_MAX : dep_q0 + 1'b1;
                end
                if (lvl_reg < LVL_TOP) begin
                    anc_we     = 1'b1;
                    anc_wlvl   = LVL_W'(lvl_reg);
                    anc_wdata  = anc_q0;
                    anc_rnode0 = anc_q0;
                    anc_rlvl   = LVL_W'(lvl_reg);
                end
                if (lvl_reg >= LVL_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            ST_SWAP: begin
                da_next   = dep_q0;
                db_next   = dep_q1;
                a_next    = swap ? b_reg : a_reg;
                b_next    = swap ? a_reg : b_reg;
                bits_next = swap ? (dep_q1 - dep_q0) : (dep_q0 - dep_q1);
                lvl_next  = '0;
                pend_next = 1'b0;
                state_next = ST_LIFT;
            end
            ST_LIFT: begin
                if (lvl_reg == LVL_TOP) begin
                    priority if (op_reg == OP_KTH) begin
                        res_next   = ANS_W'(v);
                        state_next = ST_DONE;
                    end else if (v == b_reg) begin
                        if (op_reg == OP_ANCESTOR) begin
                            res_next   = ANS_W'(v);
                            state_next = ST_DONE;
                        end else begin
                            dep_rnode0 = v;
                            state_next = ST_DIST;
                        end
                    end else begin
                        a_next     = v;
                        anc_rnode0 = v;
                        anc_rnode1 = b_reg;
                        anc_rlvl   = LVL_W'(LEVELS - 1);
                        lvl_next   = LVL_LAST;
                        state_next = ST_JUMP;
                    end
                end else begin
                    // climb 2^lvl generations where the bit is set
                    a_next     = v;
                    anc_rnode0 = v;
                    anc_rlvl   = LVL_W'(lvl_reg);
                    pend_next  = bits_reg[0];
                    bits_next  = bits_reg >> 1;
                    lvl_next   = lvl_reg + 1'b1;
                end
            end
            ST_JUMP: begin
                a_next = na;
                b_next = nb;
                anc_rnode0 = na;
                anc_rnode1 = nb;
                if (lvl_reg == '0) begin
                    anc_rlvl   = '0;
                    state_next = ST_FINAL;
                end else begin
                    anc_rlvl = LVL_W'(lvl_reg - 1'b1);
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            ST_FINAL: begin
                if (op_reg == OP_ANCESTOR) begin
                    res_next   = ANS_W'(anc_q0);
                    state_next = ST_DONE;
                end else begin
                    dep_rnode0 = anc_q0;
                    state_next = ST_DIST;
                end
            end
            ST_DIST: begin
                res_next   = span[DEPTH_W+1] ? '0 : span[ANS_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        bits_reg <= bits_next;
        lvl_reg  <= lvl_next;
        pend_reg <= pend_next;
        da_reg   <= da_next;
        db_reg   <= db_next;
        res_reg  <= res_next;
        za0_reg  <= (anc_rnode0 == '0);
        za1_reg  <= (anc_rnode1 == '0);
        zd0_reg  <= (dep_rnode0 == '0);
        zd1_reg  <= (dep_rnode1 == '0);
    end

endmodule
